// ----- rtl/core/websocket_frame_deframer_macros.svh -----
// assertion macros for the websocket frame deframer checker
// no dependencies; included by files that hold concurrent assertions
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled during reset
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsd assertion failed");

// next-cycle implication, disabled during reset
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsd assertion failed");

`endif

// ----- rtl/core/wsd_pkg.sv -----
// shared types and constants of the websocket frame deframer
// no dependencies; used by wsd_front, wsd_queue, wsd_back, the top level and the checker
package wsd_pkg;

    localparam int MASK_KEY_BYTES = 4;
    localparam int KEY_W          = 8 * MASK_KEY_BYTES;
    localparam int KEY_IDX_W      = $clog2(MASK_KEY_BYTES);
    localparam int LEN_W          = 63;
    localparam int ACC_W          = 64;
    localparam int CNT_W          = 4;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam int EXT_BYTES_16 = 2;
    localparam int EXT_BYTES_64 = 8;

    localparam logic RESULT_HEADER  = 1'b0;
    localparam logic RESULT_PAYLOAD = 1'b1;

    typedef enum logic [2:0] {
        CMD_BYTE0,
        CMD_BYTE1,
        CMD_EXTLEN,
        CMD_KEY,
        CMD_PAYLOAD
    } cmd_kind_t;

    // one classified stream byte, handed from parser to executor
    typedef struct packed {
        cmd_kind_t   kind;
        logic        emit;
        logic        last;
        logic [7:0]  data;
    } cmd_t;

    typedef struct packed {
        logic [7:0] stream_byte;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic              fin_bit;
        logic [2:0]        reserved_bits;
        logic [3:0]        opcode;
        logic              masked;
        logic [LEN_W-1:0]  payload_length;
        logic              length_top_bit_set;
        logic [7:0]        payload_byte;
        logic              frame_end;
    } out_item_t;

endpackage

// ----- rtl/core/wsd_stream_if.sv -----
// valid/ready channel carrying one item of a chosen payload type
// depends on nothing; instantiated with wsd_pkg item types
interface wsd_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/wsd_front.sv -----
// frame parser: tracks header phase and payload count, classifies each byte
// depends on wsd_pkg and wsd_stream_if
module wsd_front (
    input  logic            clk,
    input  logic            rst_n,
    wsd_stream_if.sink      stream,
    output logic            push_valid,
    input  logic            push_ready,
    output wsd_pkg::cmd_t   push_cmd
);

    typedef enum logic [2:0] {
        PH_BYTE0,
        PH_BYTE1,
        PH_EXTLEN,
        PH_KEY,
        PH_PAYLOAD
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [wsd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [wsd_pkg::CNT_W-1:0]    cnt_inc;
    logic [wsd_pkg::CNT_W-1:0]    need;
    logic                         mask_reg, mask_next;
    logic                         ext16_reg, ext16_next;
    logic [wsd_pkg::LEN_W-1:0]    rem_reg, rem_next;
    logic [wsd_pkg::LEN_W-1:0]    ext_len;
    logic [7:0]                   b;
    logic [6:0]                   code;
    logic                         accepted;

    assign stream.ready = push_ready;
    assign push_valid   = stream.valid;
    assign accepted     = stream.valid && push_ready;
    assign b            = stream.data.stream_byte;
    assign code         = b[6:0];
    assign cnt_inc      = cnt_reg + 1'b1;
    assign need         = ext16_reg ? wsd_pkg::CNT_W'(wsd_pkg::EXT_BYTES_16)
                                    : wsd_pkg::CNT_W'(wsd_pkg::EXT_BYTES_64);
    // low 63 bits only; the dropped top bit is tracked by the executor
    assign ext_len      = {rem_reg[wsd_pkg::LEN_W-9:0], b};

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        mask_next     = mask_reg;
        ext16_next    = ext16_reg;
        rem_next      = rem_reg;
        push_cmd.kind = wsd_pkg::CMD_BYTE0;
        push_cmd.emit = 1'b0;
        push_cmd.last = 1'b0;
        push_cmd.data = b;
        case (phase_reg)
            PH_BYTE0:
            begin
                push_cmd.kind = wsd_pkg::CMD_BYTE0;
                cnt_next      = '0;
                phase_next    = PH_BYTE1;
            end
            PH_BYTE1:
            begin
                push_cmd.kind = wsd_pkg::CMD_BYTE1;
                mask_next     = b[7];
                cnt_next      = '0;
                if (code == wsd_pkg::LEN_CODE_16 || code == wsd_pkg::LEN_CODE_64)
                begin
                    ext16_next = (code == wsd_pkg::LEN_CODE_16);
                    rem_next   = '0;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    rem_next = wsd_pkg::LEN_W'(code);
                    if (b[7])
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        push_cmd.emit = 1'b1;
                        push_cmd.last = (code == 7'd0);
                        phase_next    = (code == 7'd0) ? PH_BYTE0 : PH_PAYLOAD;
                    end
                end
            end
            PH_EXTLEN:
            begin
                push_cmd.kind = wsd_pkg::CMD_EXTLEN;
                rem_next      = ext_len;
                cnt_next      = cnt_inc;
                if (cnt_inc == need)
                begin
                    cnt_next = '0;
                    if (mask_reg)
                    begin
                        phase_next = PH_KEY;
                    end
                    else
                    begin
                        push_cmd.emit = 1'b1;
                        push_cmd.last = (ext_len == '0);
                        phase_next    = (ext_len == '0) ? PH_BYTE0 : PH_PAYLOAD;
                    end
                end
            end
            PH_KEY:
            begin
                push_cmd.kind = wsd_pkg::CMD_KEY;
                cnt_next      = cnt_inc;
                if (cnt_inc == wsd_pkg::CNT_W'(wsd_pkg::MASK_KEY_BYTES))
                begin
                    cnt_next      = '0;
                    push_cmd.emit = 1'b1;
                    push_cmd.last = (rem_reg == '0);
                    phase_next    = (rem_reg == '0) ? PH_BYTE0 : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                push_cmd.kind = wsd_pkg::CMD_PAYLOAD;
                if (rem_reg <= wsd_pkg::LEN_W'(1))
                begin
                    push_cmd.last = 1'b1;
                    rem_next      = '0;
                    phase_next    = PH_BYTE0;
                end
                else
                begin
                    rem_next = rem_reg - 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_BYTE0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BYTE0;
            cnt_reg   <= '0;
            mask_reg  <= 1'b0;
            ext16_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else if (accepted)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            mask_reg  <= mask_next;
            ext16_reg <= ext16_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

// ----- rtl/core/wsd_queue.sv -----
// short command queue between parser and executor
// depends on wsd_pkg
module wsd_queue #(
    parameter int DEPTH = wsd_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  wsd_pkg::cmd_t   push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output wsd_pkg::cmd_t   pop_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    wsd_pkg::cmd_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (fill_reg != FILL_W'(DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- rtl/core/wsd_back.sv -----
// executor: holds header fields and key, unmasks payload, drives result register
// depends on wsd_pkg and wsd_stream_if
module wsd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  wsd_pkg::cmd_t   pop_cmd,
    wsd_stream_if.source    result
);

    logic [7:0]                      fhb_reg, fhb_next;
    logic                            mask_reg, mask_next;
    logic [wsd_pkg::ACC_W-1:0]       len_reg, len_next;
    logic [wsd_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [wsd_pkg::KEY_IDX_W-1:0]   kidx_reg, kidx_next;
    logic                            out_valid_reg, out_valid_next;
    wsd_pkg::out_item_t              out_data_reg, out_data_next;
    logic [7:0]                      key_bytes [wsd_pkg::MASK_KEY_BYTES];
    logic [7:0]                      kb;
    logic [6:0]                      code;
    logic                            do_pop;
    logic                            produce;

    assign pop_ready    = !out_valid_reg || result.ready;
    assign do_pop       = pop_valid && pop_ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;
    assign code         = pop_cmd.data[6:0];
    assign produce      = pop_cmd.emit || (pop_cmd.kind == wsd_pkg::CMD_PAYLOAD);

    // key byte 0 is the first key byte received, the most significant
    always_comb
    begin
        for (int i = 0; i < wsd_pkg::MASK_KEY_BYTES; i++)
        begin
            key_bytes[i] = key_reg[wsd_pkg::KEY_W - 8 * (i + 1) +: 8];
        end
    end

    assign kb = mask_reg ? key_bytes[kidx_reg] : 8'd0;

    always_comb
    begin
        fhb_next  = fhb_reg;
        mask_next = mask_reg;
        len_next  = len_reg;
        key_next  = key_reg;
        kidx_next = kidx_reg;
        case (pop_cmd.kind)
            wsd_pkg::CMD_BYTE0:
            begin
                fhb_next = pop_cmd.data;
            end
            wsd_pkg::CMD_BYTE1:
            begin
                mask_next = pop_cmd.data[7];
                if (code == wsd_pkg::LEN_CODE_16 || code == wsd_pkg::LEN_CODE_64)
                begin
                    len_next = '0;
                end
                else
                begin
                    len_next = wsd_pkg::ACC_W'(code);
                end
            end
            wsd_pkg::CMD_EXTLEN:
            begin
                len_next = {len_reg[wsd_pkg::ACC_W-9:0], pop_cmd.data};
            end
            wsd_pkg::CMD_KEY:
            begin
                key_next = {key_reg[wsd_pkg::KEY_W-9:0], pop_cmd.data};
            end
            wsd_pkg::CMD_PAYLOAD:
            begin
                kidx_next = kidx_reg + 1'b1;
            end
            default:
            begin
                fhb_next = fhb_reg;
            end
        endcase
        if (pop_cmd.emit)
        begin
            kidx_next = '0;
        end
    end

    always_comb
    begin
        out_data_next.result_kind        = (pop_cmd.kind == wsd_pkg::CMD_PAYLOAD)
                                           ? wsd_pkg::RESULT_PAYLOAD
                                           : wsd_pkg::RESULT_HEADER;
        out_data_next.fin_bit            = fhb_next[7];
        out_data_next.reserved_bits      = fhb_next[6:4];
        out_data_next.opcode             = fhb_next[3:0];
        out_data_next.masked             = mask_next;
        out_data_next.payload_length     = len_next[wsd_pkg::LEN_W-1:0];
        out_data_next.length_top_bit_set = len_next[wsd_pkg::ACC_W-1];
        out_data_next.payload_byte       = (pop_cmd.kind == wsd_pkg::CMD_PAYLOAD)
                                           ? (pop_cmd.data ^ kb) : 8'd0;
        out_data_next.frame_end          = pop_cmd.last;

        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (do_pop && produce)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && produce)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fhb_reg       <= '0;
            mask_reg      <= 1'b0;
            len_reg       <= '0;
            key_reg       <= '0;
            kidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (do_pop)
            begin
                fhb_reg  <= fhb_next;
                mask_reg <= mask_next;
                len_reg  <= len_next;
                key_reg  <= key_next;
                kidx_reg <= kidx_next;
            end
        end
    end

endmodule

// ----- rtl/core/websocket_frame_deframer.sv -----
// websocket frame deframer: takes a frame byte stream, one byte per item, and
// returns one header item per frame followed by one item per payload byte,
// unmasked with the frame's key. the block sustains one byte per cycle while
// the result side is not stalled: the parser performs a single state update
// per byte and the executor produces at most one result per byte, so input
// runs at one item a cycle and output at up to one. an accepted byte is
// written into the command queue at its accepting edge and from there into
// the result register, which presents the result. a stalled output is absorbed
// by the result register plus the command queue (QUEUE_DEPTH entries) before
// the input ready drops. header bytes that do not complete a header produce no
// result. a zero-length frame gives only its header item, with frame_end set.
// a 64-bit length reports its low 63 bits in payload_length and the dropped
// top bit in length_top_bit_set. there is no reset sweep: the block is ready
// right after reset.
// depends on wsd_pkg, wsd_stream_if, wsd_front, wsd_queue and wsd_back
module websocket_frame_deframer #(
    parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    wsd_stream_if.sink      stream,
    wsd_stream_if.source    result
);

    // parser to queue
    logic            push_valid;
    logic            push_ready;
    wsd_pkg::cmd_t   push_cmd;

    // queue to executor
    logic            pop_valid;
    logic            pop_ready;
    wsd_pkg::cmd_t   pop_cmd;

    // front: header phase, extended length and payload byte count
    wsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decouples a stalled result side from the byte stream
    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // back: header fields, masking key, unmasking and the result register
    wsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .result    (result)
    );

endmodule

// ----- rtl/core/wsd_checker.sv -----
// port-level checks of the websocket frame deframer, bound to the top level
// depends on wsd_pkg and websocket_frame_deframer_macros.svh
`include "websocket_frame_deframer_macros.svh"

module wsd_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input wsd_pkg::out_item_t   out_data
);

    // a header item is due after reset and after every frame end
    logic expect_header_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
        end
        else if (out_valid && out_ready)
        begin
            expect_header_reg <= out_data.frame_end;
        end
    end

    `WSD_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid)
    `WSD_ASSERT_NEXT(a_result_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))
    `WSD_ASSERT_NOW(a_header_order, clk, rst_n, out_valid, (out_data.result_kind == wsd_pkg::RESULT_HEADER) == expect_header_reg)
    `WSD_ASSERT_NOW(a_empty_frame_ends, clk, rst_n, out_valid && out_data.result_kind == wsd_pkg::RESULT_HEADER && out_data.payload_length == '0, out_data.frame_end)

endmodule

bind websocket_frame_deframer wsd_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

// ----- test/tb_top.sv -----
// self-checking bench for websocket_frame_deframer: frame byte stream in,
// header and unmasked payload items out, checked against an in-bench parser
// depends on wsd_pkg, wsd_stream_if and the websocket_frame_deframer rtl
`timescale 1ns / 100ps

module tb_top;

    // length encodings of header byte 1
    localparam int ENC_SHORT = 0;
    localparam int ENC_16    = 1;
    localparam int ENC_64    = 2;

    localparam int STALL_LIMIT = 2000;   // cycles with no item moving on either side
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off
    localparam int HOLD_AFTER  = 200;    // results seen before the hold-off starts
    localparam int IDLE_PCT    = 29;

    // one byte waiting to be sent; drain holds it back until all results are in
    typedef struct packed {
        logic [7:0] value;
        logic       drain;
    } pending_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // bench-side drivers, known from time zero
    logic              byte_valid   = 1'b0;
    wsd_pkg::in_item_t byte_item    = '0;
    logic              result_ready = 1'b0;

    wsd_stream_if #(.payload_t(wsd_pkg::in_item_t))  stream_ch ();
    wsd_stream_if #(.payload_t(wsd_pkg::out_item_t)) result_ch ();

    assign stream_ch.valid = byte_valid;
    assign stream_ch.data  = byte_item;
    assign result_ch.ready = result_ready;

    websocket_frame_deframer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch)
    );

    pending_byte_t      stim_bytes[$];
    wsd_pkg::out_item_t expected_results[$];

    int unsigned cycle_no       = 0;
    int unsigned stall_cycles   = 0;
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    logic        quiet_phase;

    // a stretch where neither side idles
    assign quiet_phase = (cycle_no >= 1200) && (cycle_no < 1800);

    // ------------------------------------------------------------------
    // parser state mirrored in the bench
    // ------------------------------------------------------------------
    wsd_pkg::cmd_kind_t            parse_state = wsd_pkg::CMD_BYTE0;
    logic [3:0]                    hdr_count   = '0;
    logic [7:0]                    hdr_byte0   = '0;
    logic                          key_present = 1'b0;
    logic [6:0]                    len_code    = '0;
    logic [wsd_pkg::ACC_W-1:0]     len_acc     = '0;
    logic [wsd_pkg::KEY_W-1:0]     mask_key    = '0;
    logic [wsd_pkg::LEN_W-1:0]     body_left   = '0;
    logic [wsd_pkg::KEY_IDX_W-1:0] key_pos     = '0;

    // header fields as they are repeated on every item of the frame
    function automatic wsd_pkg::out_item_t frame_summary(input logic kind);
        wsd_pkg::out_item_t r;
        r                    = '0;
        r.result_kind        = kind;
        r.fin_bit            = hdr_byte0[7];
        r.reserved_bits      = hdr_byte0[6:4];
        r.opcode             = hdr_byte0[3:0];
        r.masked             = key_present;
        r.payload_length     = len_acc[wsd_pkg::LEN_W-1:0];
        r.length_top_bit_set = len_acc[wsd_pkg::ACC_W-1];
        return r;
    endfunction

    // advance the mirrored parser by one accepted byte, queue what it yields
    task automatic deframe_byte(input logic [7:0] b);
        wsd_pkg::out_item_t r;
        logic       emit;
        logic       length_done;
        logic       header_done;
        logic [7:0] key_byte;
        int         need;
        r           = '0;
        emit        = 1'b0;
        length_done = 1'b0;
        header_done = 1'b0;
        case (parse_state)
            wsd_pkg::CMD_BYTE0:
            begin
                hdr_byte0   = b;
                hdr_count   = '0;
                parse_state = wsd_pkg::CMD_BYTE1;
            end
            wsd_pkg::CMD_BYTE1:
            begin
                key_present = b[7];
                len_code    = b[6:0];
                hdr_count   = '0;
                if (len_code == wsd_pkg::LEN_CODE_16 || len_code == wsd_pkg::LEN_CODE_64)
                begin
                    len_acc     = '0;
                    parse_state = wsd_pkg::CMD_EXTLEN;
                end
                else
                begin
                    len_acc     = {{(wsd_pkg::ACC_W-7){1'b0}}, len_code};
                    length_done = 1'b1;
                end
            end
            wsd_pkg::CMD_EXTLEN:
            begin
                need      = (len_code == wsd_pkg::LEN_CODE_16) ? wsd_pkg::EXT_BYTES_16
                                                               : wsd_pkg::EXT_BYTES_64;
                len_acc   = {len_acc[wsd_pkg::ACC_W-9:0], b};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= need)
                    length_done = 1'b1;
            end
            wsd_pkg::CMD_KEY:
            begin
                mask_key  = {mask_key[wsd_pkg::KEY_W-9:0], b};
                hdr_count = hdr_count + 4'd1;
                if (hdr_count >= wsd_pkg::MASK_KEY_BYTES)
                    header_done = 1'b1;
            end
            wsd_pkg::CMD_PAYLOAD:
            begin
                r        = frame_summary(wsd_pkg::RESULT_PAYLOAD);
                key_byte = key_present ? mask_key[wsd_pkg::KEY_W-1-8*key_pos -: 8] : 8'h00;
                r.payload_byte = b ^ key_byte;
                key_pos  = key_pos + 1'b1;
                if (body_left <= 1)
                begin
                    body_left   = '0;
                    r.frame_end = 1'b1;
                    parse_state = wsd_pkg::CMD_BYTE0;
                end
                else
                    body_left = body_left - 1'b1;
                emit = 1'b1;
            end
            default:
            begin
                parse_state = wsd_pkg::CMD_BYTE0;
                hdr_count   = '0;
                hdr_byte0   = '0;
                key_present = 1'b0;
                len_code    = '0;
                len_acc     = '0;
                mask_key    = '0;
                body_left   = '0;
                key_pos     = '0;
            end
        endcase
        // length known: go on to the key, or close the header right away
        if (length_done)
        begin
            hdr_count = '0;
            if (key_present)
            begin
                mask_key    = '0;
                parse_state = wsd_pkg::CMD_KEY;
            end
            else
                header_done = 1'b1;
        end
        // header complete: one summary item, zero-length frames end here
        if (header_done)
        begin
            body_left = len_acc[wsd_pkg::LEN_W-1:0];
            key_pos   = '0;
            hdr_count = '0;
            r         = frame_summary(wsd_pkg::RESULT_HEADER);
            if (body_left == 0)
            begin
                r.frame_end = 1'b1;
                parse_state = wsd_pkg::CMD_BYTE0;
            end
            else
                parse_state = wsd_pkg::CMD_PAYLOAD;
            emit = 1'b1;
        end
        if (emit)
            expected_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // stimulus: whole frames laid out byte by byte
    // ------------------------------------------------------------------
    task automatic queue_frame(input logic [7:0] b0, input logic use_mask, input int enc,
                               input logic [63:0] len_raw, input int unsigned body_bytes,
                               input logic drain);
        logic [31:0] key;
        logic [6:0]  code;
        key  = $urandom;
        code = (enc == ENC_SHORT) ? len_raw[6:0] :
               (enc == ENC_16) ? wsd_pkg::LEN_CODE_16 : wsd_pkg::LEN_CODE_64;
        stim_bytes.push_back('{value: b0, drain: drain});
        stim_bytes.push_back('{value: {use_mask, code}, drain: 1'b0});
        if (enc == ENC_16)
        begin
            stim_bytes.push_back('{value: len_raw[15:8], drain: 1'b0});
            stim_bytes.push_back('{value: len_raw[7:0], drain: 1'b0});
        end
        if (enc == ENC_64)
            for (int i = 7; i >= 0; i--)
                stim_bytes.push_back('{value: len_raw[8*i +: 8], drain: 1'b0});
        if (use_mask)
            for (int i = 3; i >= 0; i--)
                stim_bytes.push_back('{value: key[8*i +: 8], drain: 1'b0});
        repeat (body_bytes)
            stim_bytes.push_back('{value: 8'($urandom_range(0, 255)), drain: 1'b0});
    endtask

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin : main_seq
        int          sel;
        int          enc;
        int unsigned frame_no;
        logic        use_mask;
        logic [63:0] len;

        // directed frames
        // all-zero header, zero length, no key
        queue_frame(8'h00, 1'b0, ENC_SHORT, 64'd0, 0, 1'b0);
        // all header bits set, masked zero-length frame ends on its header
        queue_frame(8'hFF, 1'b1, ENC_SHORT, 64'd0, 0, 1'b0);
        // masked short frame, key index wraps
        queue_frame(8'h81, 1'b1, ENC_SHORT, 64'd5, 5, 1'b0);
        // non-minimal 16-bit length
        queue_frame(8'h02, 1'b0, ENC_16, 64'd2, 2, 1'b0);
        // 64-bit length with its top bit set, low bits give two bytes
        queue_frame(8'h8A, 1'b0, ENC_64, 64'h8000_0000_0000_0002, 2, 1'b0);
        // top bit set with nothing below it: zero-length, flag set
        queue_frame(8'h09, 1'b1, ENC_64, 64'h8000_0000_0000_0000, 0, 1'b0);

        // random well-formed frames, mostly short
        frame_no = 0;
        while (stim_bytes.size() < 1500)
        begin
            sel      = $urandom_range(0, 99);
            use_mask = 1'($urandom_range(0, 1));
            if (sel < 70)
            begin
                enc = ENC_SHORT;
                len = 64'($urandom_range(0, 20));
            end
            else if (sel < 80)
            begin
                enc = ENC_SHORT;
                len = 64'($urandom_range(21, 125));
            end
            else if (sel < 90)
            begin
                enc = ENC_16;
                len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(256, 400))
                                                  : 64'($urandom_range(0, 40));
            end
            else
            begin
                enc = ENC_64;
                len = {1'($urandom_range(0, 1)), 57'd0, 6'($urandom_range(0, 40))};
            end
            // before frames 40 and 150, where the stream runs that long, the sender waits for every pending result
            queue_frame(8'($urandom_range(0, 255)), use_mask, enc, len, len[31:0],
                        frame_no == 40 || frame_no == 150);
            frame_no++;
        end

        // largest length last: only its first bytes are sent
        queue_frame(8'h82, 1'b1, ENC_64, 64'hFFFF_FFFF_FFFF_FFFF, 6, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_bytes.size() != 0)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        // trailing cycles: anything extra shows up as an unexpected item
        repeat (8) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // byte driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : byte_drive
        logic offer;
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item  <= '0;
        end
        else
        begin
            if (byte_valid && stream_ch.ready)
                void'(stim_bytes.pop_front());
            // an offered item stays until taken
            if (!(byte_valid && !stream_ch.ready))
            begin
                offer = (stim_bytes.size() != 0) &&
                        (quiet_phase || $urandom_range(0, 99) >= IDLE_PCT);
                // a byte taken at this edge may still add expected results
                if (offer && stim_bytes[0].drain &&
                    (expected_results.size() != 0 || (byte_valid && stream_ch.ready)))
                    offer = 1'b0;
                byte_valid <= offer;
                if (offer)
                    byte_item.stream_byte <= stim_bytes[0].value;
            end
        end
    end

    // ------------------------------------------------------------------
    // prediction on accepted bytes, checking of accepted results
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_check
        wsd_pkg::out_item_t got;
        wsd_pkg::out_item_t want;
        logic               bad;
        if (rst_n)
        begin
            if (byte_valid && stream_ch.ready)
                deframe_byte(byte_item.stream_byte);

            if (result_ch.valid && result_ready)
            begin
                got = result_ch.data;
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad  = (got.result_kind !== want.result_kind) ||
                           (got.fin_bit !== want.fin_bit) ||
                           (got.reserved_bits !== want.reserved_bits) ||
                           (got.opcode !== want.opcode) ||
                           (got.masked !== want.masked) ||
                           (got.payload_length !== want.payload_length) ||
                           (got.length_top_bit_set !== want.length_top_bit_set) ||
                           (got.payload_byte !== want.payload_byte) ||
                           (got.frame_end !== want.frame_end);
                    if (bad)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("result mismatch: kind %0b/%0b len %0d/%0d top %0b/%0b",
                                     want.result_kind, got.result_kind,
                                     want.payload_length, got.payload_length,
                                     want.length_top_bit_set, got.length_top_bit_set);
                            $display("  byte %h/%h end %0b/%0b (exp %h got %h)",
                                     want.payload_byte, got.payload_byte,
                                     want.frame_end, got.frame_end, want, got);
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver pacing: random idling and one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_pace
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            // one long hold-off lets the block fill and stall its input
            if (hold_left != 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                result_ready <= 1'b0;
            end
            else
                result_ready <= quiet_phase || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // watchdog on cycles where no item moves
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (!rst_n || (byte_valid && stream_ch.ready) || (result_ch.valid && result_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
